// ----- sv/acr_pkg.sv -----
// ----------------------------------------------------------------------------
// acr_pkg
// types and constants shared by the arp cache responder
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int TIME_W  = 40;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 64;

   localparam logic [15:0]       MIN_ARP_LEN     = 16'd28;
   localparam logic [15:0]       HW_ETHERNET     = 16'd1;
   localparam logic [15:0]       PROTO_IPV4      = 16'h0800;
   localparam logic [7:0]        HW_ADDR_LEN     = 8'd6;
   localparam logic [7:0]        PROTO_ADDR_LEN  = 8'd4;
   localparam logic [15:0]       ARP_REQUEST     = 16'd1;
   localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = 40'd300000000;

   localparam logic REG_OWN_IP  = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      OP_ARP     = 2'd0,
      OP_ADD     = 2'd1,
      OP_RESOLVE = 2'd2,
      OP_TICK    = 2'd3
   } acr_op_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_HIT  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_DROP = 2'd3
   } acr_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_SCAN,
      S_FINISH
   } acr_state_type;

   typedef struct packed {
      logic              valid;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] stamp;
   } acr_entry_type;

   typedef struct packed {
      logic              match;
      logic              fresh;
      logic              older;
      logic [TIME_W-1:0] age;
   } acr_eval_type;

endpackage

// ----- sv/acr_req_if.sv -----
// ----------------------------------------------------------------------------
// acr_req_if
// request channel of the arp cache responder
// ----------------------------------------------------------------------------
interface acr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] frame_length;
   logic [15:0] hw_type;
   logic [15:0] proto_type;
   logic [7:0]  hw_len;
   logic [7:0]  proto_len;
   logic [15:0] arp_opcode;
   logic [47:0] src_mac;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [31:0] lookup_ip;

   modport source (output valid, operation, frame_length, hw_type, proto_type, hw_len,
                   proto_len, arp_opcode, src_mac, src_ip, dst_ip, lookup_ip,
                   input ready);
   modport sink   (input valid, operation, frame_length, hw_type, proto_type, hw_len,
                   proto_len, arp_opcode, src_mac, src_ip, dst_ip, lookup_ip,
                   output ready);
endinterface

// ----- sv/acr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// acr_rsp_if
// result channel of the arp cache responder
// ----------------------------------------------------------------------------
interface acr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [47:0] resolved_mac;
   logic        reply_needed;
   logic [47:0] reply_mac;
   logic [31:0] reply_ip;
   logic        request_needed;
   logic [31:0] request_ip;

   modport source (output valid, status, resolved_mac, reply_needed, reply_mac, reply_ip,
                   request_needed, request_ip, input ready);
   modport sink   (input valid, status, resolved_mac, reply_needed, reply_mac, reply_ip,
                   request_needed, request_ip, output ready);
endinterface

// ----- sv/arp_cache_responder.sv -----
// ----------------------------------------------------------------------------
// arp_cache_responder
// set-associative ipv4-to-mac cache with aging, arp validation and replies
// ----------------------------------------------------------------------------
// flow: tick or dropped packet goes straight to finish; store or resolve reads
//   the set and scans each way; non-power-of-two SETS adds a set reduction
// throughput: one beat at a time; the way scan through the shared unit sets it
// reset: a clearing pass over every set wipes the table, no beat taken meanwhile
// ----------------------------------------------------------------------------
module arp_cache_responder #(
   parameter int SETS = 256,
   parameter int WAYS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   acr_req_if.sink                     req_bus,
   acr_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [acr_pkg::ADDR_W-1:0]  paddr,
   input  logic [acr_pkg::DATA_W-1:0]  pwdata,
   output logic [acr_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import acr_pkg::*;

   localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int  WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
   localparam int  RECIP_SHIFT = IP_W + SET_W;
   localparam logic [IP_W:0]    RECIP     = (IP_W+1)'((65'd1 << RECIP_SHIFT) / SETS);
   localparam logic [IP_W-1:0]  SETS_IP   = IP_W'(SETS);
   localparam logic [SET_W:0]   SETS_WIDE = (SET_W+1)'(SETS);

   acr_entry_type [WAYS-1:0] mem [SETS];

   acr_state_type     state_ff, state_in;
   logic [IP_W-1:0]   own_ip_ff;
   logic [TIME_W-1:0] timeout_ff;
   logic [TIME_W-1:0] time_ff;
   logic [SET_W-1:0]  clr_ff;

   acr_op_type        op_ff;
   logic              drop_ff;
   logic              reply_ff;
   logic [IP_W-1:0]   key_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [IP_W-1:0]   hash_ff;
   logic              hash_step_ff;
   logic [IP_W-1:0]   quot_ff;
   logic [SET_W-1:0]  set_ff;

   acr_entry_type [WAYS-1:0] row_ff;
   logic [WAY_W-1:0]  way_ff;
   logic              match_found_ff, free_found_ff, hit_ff;
   logic [WAY_W-1:0]  match_way_ff, free_way_ff, old_way_ff;
   logic [TIME_W-1:0] oldest_ff;
   logic [MAC_W-1:0]  hit_mac_ff;

   logic              rsp_valid_ff;
   acr_status_type    status_ff;
   logic [MAC_W-1:0]  resolved_mac_ff, reply_mac_ff;
   logic              reply_needed_ff, request_needed_ff;
   logic [IP_W-1:0]   reply_ip_ff, request_ip_ff;

   logic              accept, fin_go, store_op, mem_we, req_ready;
   logic              pkt_ok, wr_cfg;
   logic [IP_W-1:0]   accept_ip, accept_hash;
   logic [2*IP_W:0]   quot_prod, quot_sh;
   logic [IP_W-1:0]   rem_prod, rem_full;
   logic [SET_W:0]    rem_est;
   logic [SET_W-1:0]  rem_next;
   logic [SET_W-1:0]  mem_addr;
   logic [WAY_W-1:0]  pick_way;
   acr_entry_type [WAYS-1:0] new_row, mem_wdata;
   acr_eval_type      eval;

   acr_way_eval u_eval (
      .entry    (row_ff[way_ff]),
      .key_ip   (key_ff),
      .time_now (time_ff),
      .timeout  (timeout_ff),
      .oldest   (oldest_ff),
      .result   (eval)
   );

   // configuration port
   assign pready = 1'b1;
   assign wr_cfg = psel && penable && pwrite;
   assign prdata = (paddr[3] == REG_TIMEOUT) ? {24'b0, timeout_ff} : {32'b0, own_ip_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         timeout_ff <= DEFAULT_TIMEOUT;
      end else if (wr_cfg) begin
         if (paddr[3] == REG_TIMEOUT) begin
            timeout_ff <= pwdata[TIME_W-1:0];
         end else begin
            own_ip_ff <= pwdata[IP_W-1:0];
         end
      end
   end

   // request decode
   assign accept      = req_bus.valid && req_ready;
   assign pkt_ok      = (req_bus.frame_length >= MIN_ARP_LEN) && (req_bus.hw_type == HW_ETHERNET)
                        && (req_bus.proto_type == PROTO_IPV4) && (req_bus.hw_len == HW_ADDR_LEN)
                        && (req_bus.proto_len == PROTO_ADDR_LEN);
   assign accept_ip   = (acr_op_type'(req_bus.operation) == OP_RESOLVE) ? req_bus.lookup_ip
                                                                         : req_bus.src_ip;
   assign accept_hash = accept_ip ^ {16'b0, accept_ip[31:16]};

   // set reduction by reciprocal multiply, then one corrective subtract
   assign quot_prod = (2*IP_W+1)'(hash_ff) * (2*IP_W+1)'(RECIP);
   assign quot_sh   = quot_prod >> RECIP_SHIFT;
   assign rem_prod  = quot_ff * SETS_IP;
   assign rem_full  = hash_ff - rem_prod;
   assign rem_est   = rem_full[SET_W:0];
   assign rem_next  = (rem_est >= SETS_WIDE) ? SET_W'(rem_est - SETS_WIDE)
                                              : rem_est[SET_W-1:0];
   assign req_bus.ready = req_ready;

   assign store_op = ((op_ff == OP_ARP) && !drop_ff) || (op_ff == OP_ADD);
   assign fin_go   = !rsp_valid_ff || rsp_bus.ready;
   assign pick_way = match_found_ff ? match_way_ff : (free_found_ff ? free_way_ff : old_way_ff);

   always_comb begin
      new_row = row_ff;
      if (store_op) begin
         new_row[pick_way].valid = 1'b1;
         new_row[pick_way].ip    = key_ff;
         new_row[pick_way].mac   = mac_ff;
         new_row[pick_way].stamp = time_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_SET) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               if (acr_op_type'(req_bus.operation) == OP_TICK
                   || (acr_op_type'(req_bus.operation) == OP_ARP && !pkt_ok)) begin
                  state_in = S_FINISH;
               end else if (SETS_POW2) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_step_ff) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (way_ff == LAST_WAY) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (fin_go) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = set_ff;
      mem_wdata = new_row;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
         end
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_FINISH: begin
            mem_we = fin_go && (store_op || op_ff == OP_RESOLVE);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == S_FINISH && fin_go && op_ff == OP_TICK) time_ff <= time_ff + 1'b1;
      end
   end

   // table storage
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
   end

   // item and scan registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_ff        <= acr_op_type'(req_bus.operation);
               drop_ff      <= !pkt_ok;
               reply_ff     <= (req_bus.dst_ip == own_ip_ff)
                               && (req_bus.arp_opcode == ARP_REQUEST);
               key_ff       <= accept_ip;
               mac_ff       <= req_bus.src_mac;
               hash_ff      <= accept_hash;
               hash_step_ff <= 1'b0;
               set_ff       <= SETS_POW2 ? SET_W'(accept_hash & IP_W'(SETS - 1)) : '0;
            end
         end
         S_HASH: begin
            if (!hash_step_ff) begin
               quot_ff      <= quot_sh[IP_W-1:0];
               hash_step_ff <= 1'b1;
            end else begin
               set_ff <= rem_next;
            end
         end
         S_READ: begin
            row_ff         <= mem[set_ff];
            way_ff         <= '0;
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
            hit_ff         <= 1'b0;
            match_way_ff   <= '0;
            free_way_ff    <= '0;
            old_way_ff     <= '0;
            oldest_ff      <= '0;
            hit_mac_ff     <= '0;
         end
         S_SCAN: begin
            way_ff <= way_ff + 1'b1;
            if (!match_found_ff && eval.match) begin
               match_found_ff <= 1'b1;
               match_way_ff   <= way_ff;
            end
            if (!free_found_ff && !eval.fresh) begin
               free_found_ff <= 1'b1;
               free_way_ff   <= way_ff;
            end
            if (way_ff == '0 || eval.older) begin
               oldest_ff  <= eval.age;
               old_way_ff <= way_ff;
            end
            if (op_ff == OP_RESOLVE && !hit_ff && eval.match) begin
               if (eval.fresh) begin
                  hit_ff     <= 1'b1;
                  hit_mac_ff <= row_ff[way_ff].mac;
               end else begin
                  row_ff[way_ff].valid <= 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && fin_go) begin
         resolved_mac_ff   <= '0;
         reply_needed_ff   <= 1'b0;
         reply_mac_ff      <= '0;
         reply_ip_ff       <= '0;
         request_needed_ff <= 1'b0;
         request_ip_ff     <= '0;
         status_ff         <= STAT_DONE;
         case (op_ff)
            OP_ARP: begin
               if (drop_ff) begin
                  status_ff <= STAT_DROP;
               end else if (reply_ff) begin
                  reply_needed_ff <= 1'b1;
                  reply_mac_ff    <= mac_ff;
                  reply_ip_ff     <= key_ff;
               end
            end
            OP_RESOLVE: begin
               if (hit_ff) begin
                  status_ff       <= STAT_HIT;
                  resolved_mac_ff <= hit_mac_ff;
               end else begin
                  status_ff         <= STAT_MISS;
                  request_needed_ff <= 1'b1;
                  request_ip_ff     <= key_ff;
               end
            end
            default: begin
               status_ff <= STAT_DONE;
            end
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.resolved_mac   = resolved_mac_ff;
   assign rsp_bus.reply_needed   = reply_needed_ff;
   assign rsp_bus.reply_mac      = reply_mac_ff;
   assign rsp_bus.reply_ip       = reply_ip_ff;
   assign rsp_bus.request_needed = request_needed_ff;
   assign rsp_bus.request_ip     = request_ip_ff;
endmodule

// ----- sv/acr_way_eval.sv -----
// ----------------------------------------------------------------------------
// acr_way_eval
// shared way unit: address match, age, freshness and oldest compare
// ----------------------------------------------------------------------------
module acr_way_eval (
   input  acr_pkg::acr_entry_type      entry,
   input  logic [acr_pkg::IP_W-1:0]    key_ip,
   input  logic [acr_pkg::TIME_W-1:0]  time_now,
   input  logic [acr_pkg::TIME_W-1:0]  timeout,
   input  logic [acr_pkg::TIME_W-1:0]  oldest,
   output acr_pkg::acr_eval_type       result
);
   import acr_pkg::*;

   logic [TIME_W-1:0] age;

   assign age          = time_now - entry.stamp;
   assign result.age   = age;
   assign result.match = entry.valid && (entry.ip == key_ip);
   assign result.fresh = entry.valid && (age < timeout);
   assign result.older = age > oldest;
endmodule
